>>> rtl/ppm_header_and_pixel_parser_defines.svh
// ----------------------------------------------------------------------------
// PPM parser assertion macros
// Assertion shorthands for the PPM parser; disabled when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef PPM_HEADER_AND_PIXEL_PARSER_DEFINES_SVH
`define PPM_HEADER_AND_PIXEL_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define PPMP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppm parser: implication failed");
// Next-cycle implication.
`define PPMP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppm parser: next-cycle implication failed");
`else
`define PPMP_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PPMP_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/ppmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM parser package
// Request types, token type and fixed codes shared by the parser modules.
// ----------------------------------------------------------------------------
package ppmp_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       file_start;
    } t_in_item;

    typedef struct packed {
        t_kind       result_kind;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] max_value;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last_pixel;
    } t_out_item;

    // Classified byte as it sits in the queue between front and back.
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       is_space;
        logic       is_digit;
        logic [3:0] digit;
    } t_tok;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_ZERO  = 8'h30;

endpackage

>>> rtl/ppmp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM parser front end
// Accepts file bytes, classifies them as whitespace or digit and holds them
// in a two-entry queue for the parser.
// ----------------------------------------------------------------------------
module ppmp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ppmp_pkg::t_in_item i_in_data,
    output logic               o_in_stall,
    input  logic               i_pop,
    output logic               o_tok_valid,
    output ppmp_pkg::t_tok     o_tok
);

    localparam int PTR_W = $clog2(ppmp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ppmp_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ppmp_pkg::QUEUE_DEPTH);

    ppmp_pkg::t_tok r_q [ppmp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    ppmp_pkg::t_tok   w_tok_in;
    logic             w_push;
    logic             w_pop;

    always_comb begin
        w_tok_in.data     = i_in_data.in_byte;
        w_tok_in.start    = i_in_data.file_start;
        w_tok_in.is_space = i_in_data.in_byte inside {[8'd9:8'd13], 8'd32};
        w_tok_in.is_digit = i_in_data.in_byte inside {[8'h30:8'h39]};
        w_tok_in.digit    = 4'(i_in_data.in_byte - ppmp_pkg::CH_ZERO);
    end

    assign o_in_stall  = (r_count == FULL_CNT);
    assign o_tok_valid = (r_count != '0);
    assign o_tok       = r_q[r_rd_ptr];
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = i_pop && o_tok_valid;

    always_comb begin
        n_wr_ptr = w_push ? PTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? PTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (w_pop && !w_push) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_tok_in;
        end
    end

endmodule

>>> rtl/ppmp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM parser back end
// Header state machine, pixel assembly and the output register.
// ----------------------------------------------------------------------------
module ppmp_back #(
    parameter int DIM_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tok_valid,
    input  ppmp_pkg::t_tok      i_tok,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ppmp_pkg::t_out_item o_out_data
);

    localparam int DIM_W = (DIM_BITS < 16) ? DIM_BITS : 16;
    localparam logic [15:0] DIM_LIM = 16'((32'd1 << DIM_W) - 32'd1);

    typedef enum logic [10:0] {
        PH_MAGIC0 = 11'b000_0000_0001,
        PH_MAGIC1 = 11'b000_0000_0010,
        PH_SKIP   = 11'b000_0000_0100,
        PH_WS_W   = 11'b000_0000_1000,
        PH_NUM_W  = 11'b000_0001_0000,
        PH_WS_H   = 11'b000_0010_0000,
        PH_NUM_H  = 11'b000_0100_0000,
        PH_WS_M   = 11'b000_1000_0000,
        PH_NUM_M  = 11'b001_0000_0000,
        PH_PIX    = 11'b010_0000_0000,
        PH_DONE   = 11'b100_0000_0000
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [1:0]          r_bip, n_bip;
    logic [15:0]         r_acc, n_acc;
    logic [15:0]         r_width, n_width;
    logic [15:0]         r_height, n_height;
    logic [15:0]         r_maxval, n_maxval;
    logic [DIM_W-1:0]    r_col, n_col;
    logic [DIM_W-1:0]    r_row, n_row;
    logic [7:0]          r_red, n_red;
    logic [7:0]          r_green, n_green;
    logic                r_out_valid, n_out_valid;
    ppmp_pkg::t_out_item r_out, n_out;

    t_phase              w_ph;
    logic                w_emit;
    logic                w_hdr;
    logic [15:0]         w_acc_sat;
    logic [19:0]         w_mac;
    logic [DIM_W-1:0]    w_col_last;
    logic [DIM_W-1:0]    w_row_last;
    logic                w_last;
    ppmp_pkg::t_out_item w_res;

    function automatic logic [15:0] f_clamp(input logic [15:0] v);
        return (v > DIM_LIM) ? DIM_LIM : v;
    endfunction

    // Take a byte whenever the output register is free or being drained.
    assign o_pop = i_tok_valid && (!r_out_valid || !i_out_stall);

    assign w_ph       = i_tok.start ? PH_MAGIC0 : r_phase;
    assign w_mac      = 20'(r_acc) * 20'd10 + 20'(i_tok.digit);
    assign w_acc_sat  = (w_mac > 20'h0FFFF) ? 16'hFFFF : w_mac[15:0];
    assign w_col_last = DIM_W'(r_width[DIM_W-1:0] - 1'b1);
    assign w_row_last = DIM_W'(r_height[DIM_W-1:0] - 1'b1);
    assign w_last     = (r_col == w_col_last) && (r_row == w_row_last);

    always_comb begin
        n_phase  = r_phase;
        n_bip    = r_bip;
        n_acc    = r_acc;
        n_width  = r_width;
        n_height = r_height;
        n_maxval = r_maxval;
        n_col    = r_col;
        n_row    = r_row;
        n_red    = r_red;
        n_green  = r_green;
        w_emit   = 1'b0;
        w_hdr    = 1'b0;
        w_res    = '0;

        case (w_ph)
            PH_MAGIC0: begin
                if (i_tok.data == ppmp_pkg::CH_P) begin
                    n_phase = PH_MAGIC1;
                end else begin
                    n_phase           = PH_DONE;
                    w_emit            = 1'b1;
                    w_res.result_kind = ppmp_pkg::KIND_ERROR;
                end
            end
            PH_MAGIC1: begin
                if (i_tok.data == ppmp_pkg::CH_SIX || i_tok.data == ppmp_pkg::CH_THREE) begin
                    n_phase = PH_SKIP;
                end else begin
                    n_phase           = PH_DONE;
                    w_emit            = 1'b1;
                    w_res.result_kind = ppmp_pkg::KIND_ERROR;
                end
            end
            PH_SKIP: begin
                n_phase = PH_WS_W;
            end
            PH_WS_W: begin
                if (i_tok.is_digit) begin
                    n_acc   = 16'(i_tok.digit);
                    n_phase = PH_NUM_W;
                end else if (!i_tok.is_space) begin
                    // Missing numbers fall through to an all-zero header.
                    n_width  = '0;
                    n_height = '0;
                    n_maxval = '0;
                    w_hdr    = 1'b1;
                end
            end
            PH_NUM_W: begin
                if (i_tok.is_digit) begin
                    n_acc = w_acc_sat;
                end else if (i_tok.is_space) begin
                    n_width = f_clamp(r_acc);
                    n_phase = PH_WS_H;
                end else begin
                    n_width  = f_clamp(r_acc);
                    n_height = '0;
                    n_maxval = '0;
                    w_hdr    = 1'b1;
                end
            end
            PH_WS_H: begin
                if (i_tok.is_digit) begin
                    n_acc   = 16'(i_tok.digit);
                    n_phase = PH_NUM_H;
                end else if (!i_tok.is_space) begin
                    n_height = '0;
                    n_maxval = '0;
                    w_hdr    = 1'b1;
                end
            end
            PH_NUM_H: begin
                if (i_tok.is_digit) begin
                    n_acc = w_acc_sat;
                end else if (i_tok.is_space) begin
                    n_height = f_clamp(r_acc);
                    n_phase  = PH_WS_M;
                end else begin
                    n_height = f_clamp(r_acc);
                    n_maxval = '0;
                    w_hdr    = 1'b1;
                end
            end
            PH_WS_M: begin
                if (i_tok.is_digit) begin
                    n_acc   = 16'(i_tok.digit);
                    n_phase = PH_NUM_M;
                end else if (!i_tok.is_space) begin
                    n_maxval = '0;
                    w_hdr    = 1'b1;
                end
            end
            PH_NUM_M: begin
                if (i_tok.is_digit) begin
                    n_acc = w_acc_sat;
                end else begin
                    // Any non-digit here is the single separator byte.
                    n_maxval = r_acc;
                    w_hdr    = 1'b1;
                end
            end
            PH_PIX: begin
                case (r_bip)
                    2'd0: begin
                        n_red = i_tok.data;
                        n_bip = 2'd1;
                    end
                    2'd1: begin
                        n_green = i_tok.data;
                        n_bip   = 2'd2;
                    end
                    default: begin
                        n_bip              = 2'd0;
                        w_emit             = 1'b1;
                        w_res.result_kind  = ppmp_pkg::KIND_PIXEL;
                        w_res.image_width  = r_width;
                        w_res.image_height = r_height;
                        w_res.max_value    = r_maxval;
                        w_res.red          = r_red;
                        w_res.green        = r_green;
                        w_res.blue         = i_tok.data;
                        w_res.last_pixel   = w_last;
                        if (w_last) begin
                            n_phase = PH_DONE;
                        end else if (r_col == w_col_last) begin
                            n_col = '0;
                            n_row = DIM_W'(r_row + 1'b1);
                        end else begin
                            n_col = DIM_W'(r_col + 1'b1);
                        end
                    end
                endcase
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        if (w_hdr) begin
            n_acc              = '0;
            n_bip              = 2'd0;
            n_col              = '0;
            n_row              = '0;
            n_phase            = (n_width == '0 || n_height == '0) ? PH_DONE : PH_PIX;
            w_emit             = 1'b1;
            w_res.result_kind  = ppmp_pkg::KIND_HEADER;
            w_res.image_width  = n_width;
            w_res.image_height = n_height;
            w_res.max_value    = n_maxval;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (o_pop && w_emit) begin
            n_out_valid = 1'b1;
            n_out       = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAGIC0;
            r_bip       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_phase <= n_phase;
                r_bip   <= n_bip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (o_pop) begin
            r_acc    <= n_acc;
            r_width  <= n_width;
            r_height <= n_height;
            r_maxval <= n_maxval;
            r_col    <= n_col;
            r_row    <= n_row;
            r_red    <= n_red;
            r_green  <= n_green;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/ppm_header_and_pixel_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM header and pixel parser
// Parses P6/P3 bytes into one header request and raw RGB pixels, or an error.
// ----------------------------------------------------------------------------
// Takes one file byte per clock while not stalled and gives at most one
// result per byte. A byte first enters a two-entry queue in the front end,
// where it is classified; the back end parses one queued byte per clock
// while its output register is free or being drained and puts any result
// in that output register, where it waits to be accepted. The input stalls
// only when the queue is full, which happens only while the output is held
// by a downstream stall. A file restarts on any byte that carries file_start.
// Width and height are limited to 2^DIM_BITS - 1 and never exceed 65535.
// ----------------------------------------------------------------------------
`include "ppm_header_and_pixel_parser_defines.svh"

module ppm_header_and_pixel_parser #(
    parameter int DIM_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ppmp_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ppmp_pkg::t_out_item o_out_data
);

    logic           w_tok_valid;
    ppmp_pkg::t_tok w_tok;
    logic           w_pop;
    logic           w_out_err;
    logic           w_out_dims_zero;
    logic           w_out_last;
    logic           w_out_pixel;

    ppmp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_pop       (w_pop),
        .o_tok_valid (w_tok_valid),
        .o_tok       (w_tok)
    );

    ppmp_back #(
        .DIM_BITS (DIM_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_tok_valid),
        .i_tok       (w_tok),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    assign w_out_err       = o_out_valid && (o_out_data.result_kind == ppmp_pkg::KIND_ERROR);
    assign w_out_dims_zero = (o_out_data.image_width == 16'd0) &&
                             (o_out_data.image_height == 16'd0) &&
                             (o_out_data.max_value == 16'd0);
    assign w_out_last      = o_out_valid && o_out_data.last_pixel;
    assign w_out_pixel     = (o_out_data.result_kind == ppmp_pkg::KIND_PIXEL);

    `PPMP_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, w_out_err, w_out_dims_zero)
    `PPMP_ASSERT_IMP(a_last_is_pixel, i_clk, i_rst_n, w_out_last, w_out_pixel)
    `PPMP_ASSERT_IMP(a_stall_has_data, i_clk, i_rst_n, o_in_stall, w_tok_valid)
    `PPMP_ASSERT_IMP(a_no_pop_blocked, i_clk, i_rst_n, o_out_valid && i_out_stall, !w_pop)
    `PPMP_ASSERT_NXT(a_empty_stays, i_clk, i_rst_n, !w_tok_valid && !i_in_valid, !w_tok_valid)

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM parser testbench
// Streams PPM files into the parser, one byte per request, and predicts each
// header, pixel and format-error result from a byte-level parser model.
// Runs several traffic phases with random sender gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          DIM_BITS       = 16;
    localparam int unsigned DIM_MAX        = (DIM_BITS >= 16) ? 32'hFFFF
                                                              : (32'd1 << DIM_BITS) - 1;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned PHASE_BYTES    = 210;
    localparam int unsigned NUM_PHASES     = 5;
    localparam logic [7:0]  CH_NINE        = ppmp_pkg::CH_ZERO + 8'd9;

    typedef enum logic [3:0] {
        ST_MAGIC0, ST_MAGIC1, ST_SKIP,
        ST_WS_W, ST_NUM_W, ST_WS_H, ST_NUM_H, ST_WS_M, ST_NUM_M,
        ST_PIX, ST_DONE
    } t_parse_st;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    ppmp_pkg::t_in_item  i_in_data   = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    ppmp_pkg::t_out_item o_out_data;

    ppmp_pkg::t_in_item  file_bytes[$];
    ppmp_pkg::t_out_item parsed_results[$];
    int unsigned send_idle_pct = 0;
    int unsigned out_stall_pct = 0;
    int unsigned stim_count    = 0;
    int unsigned n_errors      = 0;
    int unsigned idle_cycles   = 0;

    // parser state
    t_parse_st   parse_st;
    logic [15:0] num_acc;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic [15:0] img_max;
    logic [31:0] pix_left;
    logic [1:0]  pix_byte;
    logic [7:0]  red_q;
    logic [7:0]  green_q;

    ppm_header_and_pixel_parser #(
        .DIM_BITS(DIM_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic void clear_parse();
        parse_st = ST_MAGIC0;
        num_acc  = '0;
        img_w    = '0;
        img_h    = '0;
        img_max  = '0;
        pix_left = '0;
        pix_byte = '0;
        red_q    = '0;
        green_q  = '0;
    endfunction

    // Store a finished width or height and move on to the next number.
    function automatic void store_dim();
        logic [15:0] v;
        v = (32'(num_acc) > DIM_MAX) ? 16'(DIM_MAX) : num_acc;
        if (parse_st == ST_WS_W || parse_st == ST_NUM_W) begin
            img_w    = v;
            parse_st = ST_WS_H;
        end else begin
            img_h    = v;
            parse_st = ST_WS_M;
        end
        num_acc = '0;
    endfunction

    function automatic ppmp_pkg::t_out_item close_header();
        ppmp_pkg::t_out_item res;
        img_max  = num_acc;
        num_acc  = '0;
        pix_left = 32'(img_w) * 32'(img_h);
        pix_byte = '0;
        parse_st = (pix_left == 0) ? ST_DONE : ST_PIX;
        res = '0;
        res.result_kind  = ppmp_pkg::KIND_HEADER;
        res.image_width  = img_w;
        res.image_height = img_h;
        res.max_value    = img_max;
        return res;
    endfunction

    function automatic bit parse_byte(input ppmp_pkg::t_in_item req,
                                      output ppmp_pkg::t_out_item res);
        logic [7:0]  b;
        bit          is_ws;
        bit          is_dig;
        int unsigned v;
        b      = req.in_byte;
        is_ws  = (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
        is_dig = (b >= ppmp_pkg::CH_ZERO) && (b <= CH_NINE);
        res    = '0;
        if (req.file_start) clear_parse();
        // a byte that ends an empty number falls through to the next stage
        repeat (4) begin
            case (parse_st)
                ST_MAGIC0, ST_MAGIC1: begin
                    if ((parse_st == ST_MAGIC0 && b == ppmp_pkg::CH_P) ||
                        (parse_st == ST_MAGIC1 &&
                         (b == ppmp_pkg::CH_SIX || b == ppmp_pkg::CH_THREE))) begin
                        parse_st = t_parse_st'(parse_st + 1);
                        return 1'b0;
                    end
                    parse_st        = ST_DONE;
                    res.result_kind = ppmp_pkg::KIND_ERROR;
                    return 1'b1;
                end
                ST_SKIP: begin
                    parse_st = ST_WS_W;
                    return 1'b0;
                end
                ST_WS_W, ST_WS_H, ST_WS_M: begin
                    if (is_ws) return 1'b0;
                    if (is_dig) begin
                        num_acc  = 16'(b - ppmp_pkg::CH_ZERO);
                        parse_st = t_parse_st'(parse_st + 1);
                        return 1'b0;
                    end
                    num_acc = '0;
                    if (parse_st == ST_WS_M) begin
                        res = close_header();
                        return 1'b1;
                    end
                    store_dim();
                end
                ST_NUM_W, ST_NUM_H, ST_NUM_M: begin
                    if (is_dig) begin
                        v = 32'(num_acc) * 32'd10 + 32'(b) - 32'(ppmp_pkg::CH_ZERO);
                        num_acc = (v > 32'hFFFF) ? 16'hFFFF : 16'(v);
                        return 1'b0;
                    end
                    if (parse_st == ST_NUM_M) begin
                        res = close_header();
                        return 1'b1;
                    end
                    store_dim();
                end
                ST_PIX: begin
                    if (pix_byte == 2'd0) begin
                        red_q    = b;
                        pix_byte = 2'd1;
                        return 1'b0;
                    end
                    if (pix_byte == 2'd1) begin
                        green_q  = b;
                        pix_byte = 2'd2;
                        return 1'b0;
                    end
                    pix_byte = 2'd0;
                    pix_left = pix_left - 1;
                    if (pix_left == 0) parse_st = ST_DONE;
                    res.result_kind  = ppmp_pkg::KIND_PIXEL;
                    res.image_width  = img_w;
                    res.image_height = img_h;
                    res.max_value    = img_max;
                    res.red          = red_q;
                    res.green        = green_q;
                    res.blue         = b;
                    res.last_pixel   = (pix_left == 0);
                    return 1'b1;
                end
                default: begin
                    return 1'b0;
                end
            endcase
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // File generation
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic start);
        ppmp_pkg::t_in_item req;
        req.in_byte    = b;
        req.file_start = start;
        file_bytes.push_back(req);
        stim_count++;
    endtask

    // Append random trailing bytes, dropped once a file is done; they do not count toward the phase.
    task automatic push_junk(input int unsigned n);
        repeat (n) push_byte(8'($urandom_range(255)), 1'b0);
        stim_count -= n;
    endtask

    task automatic push_text(input string s, input logic start);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], start && i == 0);
    endtask

    function automatic logic [7:0] pick_space();
        int unsigned k;
        k = $urandom_range(5);
        return (k == 5) ? 8'h20 : 8'(9 + k);
    endfunction

    task automatic push_number(input int unsigned val, input int unsigned min_ws);
        string s;
        repeat ($urandom_range(min_ws, 3)) push_byte(pick_space(), 1'b0);
        repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0)
            push_byte(ppmp_pkg::CH_ZERO, 1'b0);
        s = $sformatf("%0d", val);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
    endtask

    function automatic int unsigned pick_dim();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 4) return 0;
        if (k < 7) return $urandom_range(65535, 9999999);
        return $urandom_range(1, 4);
    endfunction

    task automatic gen_file();
        int unsigned k;
        int unsigned w;
        int unsigned h;
        int unsigned nbytes;
        logic [7:0]  b;
        k = $urandom_range(99);
        if (k < 8) begin
            // noise, now and then restarting a file
            repeat ($urandom_range(1, 6))
                push_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
        end else if (k < 16) begin
            if ($urandom_range(1)) begin
                push_byte(ppmp_pkg::CH_P, 1'b1);
                do b = 8'($urandom_range(255));
                while (b == ppmp_pkg::CH_SIX || b == ppmp_pkg::CH_THREE);
                push_byte(b, 1'b0);
            end else begin
                do b = 8'($urandom_range(255)); while (b == ppmp_pkg::CH_P);
                push_byte(b, 1'b1);
            end
            push_junk($urandom_range(3));
        end else begin
            push_byte(ppmp_pkg::CH_P, 1'b1);
            push_byte($urandom_range(1) ? ppmp_pkg::CH_SIX : ppmp_pkg::CH_THREE, 1'b0);
            push_byte(8'($urandom_range(255)), 1'b0);
            w = pick_dim();
            h = pick_dim();
            push_number(w, 0);
            if ($urandom_range(15) == 0) begin
                // cut the header short with a stray byte: the rest reads as zero
                do b = 8'($urandom_range(255));
                while ((b >= ppmp_pkg::CH_ZERO && b <= CH_NINE) || b == 8'h20 ||
                       (b >= 8'd9 && b <= 8'd13));
                push_byte(b, 1'b0);
                nbytes = 0;
            end else begin
                push_number(h, 1);
                push_number(($urandom_range(3) == 0) ? $urandom_range(99999) : 255, 1);
                if ($urandom_range(3) != 0) begin
                    b = pick_space();
                end else begin
                    do b = 8'($urandom_range(255));
                    while (b >= ppmp_pkg::CH_ZERO && b <= CH_NINE);
                end
                push_byte(b, 1'b0);
                if (w > 65535) w = 65535;
                if (h > 65535) h = 65535;
                if (w * h <= 32) begin
                    nbytes = w * h * 3;
                    if ($urandom_range(7) == 0) nbytes = $urandom_range(nbytes);
                end else begin
                    nbytes = $urandom_range(3, 30);
                end
            end
            repeat (nbytes) push_byte(8'($urandom_range(255)), 1'b0);
            if ($urandom_range(3) == 0) push_junk($urandom_range(1, 4));
        end
    endtask

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // Request driver and output stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (file_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= file_bytes.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        ppmp_pkg::t_out_item pred;
        ppmp_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                if (parse_byte(i_in_data, pred)) parsed_results.push_back(pred);
            end
            if (o_out_valid && !i_out_stall) begin
                if (parsed_results.size() == 0) begin
                    flag_mismatch("result with nothing expected");
                end else begin
                    want = parsed_results.pop_front();
                    if (o_out_data.result_kind !== want.result_kind)
                        flag_mismatch($sformatf("kind got %0d want %0d",
                                      o_out_data.result_kind, want.result_kind));
                    if (o_out_data.image_width !== want.image_width)
                        flag_mismatch($sformatf("width got %0d want %0d",
                                      o_out_data.image_width, want.image_width));
                    if (o_out_data.image_height !== want.image_height)
                        flag_mismatch($sformatf("height got %0d want %0d",
                                      o_out_data.image_height, want.image_height));
                    if (o_out_data.max_value !== want.max_value)
                        flag_mismatch($sformatf("maxval got %0d want %0d",
                                      o_out_data.max_value, want.max_value));
                    if (o_out_data.red !== want.red)
                        flag_mismatch($sformatf("red got %0d want %0d",
                                      o_out_data.red, want.red));
                    if (o_out_data.green !== want.green)
                        flag_mismatch($sformatf("green got %0d want %0d",
                                      o_out_data.green, want.green));
                    if (o_out_data.blue !== want.blue)
                        flag_mismatch($sformatf("blue got %0d want %0d",
                                      o_out_data.blue, want.blue));
                    if (o_out_data.last_pixel !== want.last_pixel)
                        flag_mismatch($sformatf("last got %0d want %0d",
                                      o_out_data.last_pixel, want.last_pixel));
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TIMEOUT: no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned idle_tab[NUM_PHASES];
        int unsigned stall_tab[NUM_PHASES];
        idle_tab  = '{0, 49, 0, 36, 0};
        stall_tab = '{0, 0, 49, 36, 0};
        clear_parse();

        // first file without a start flag: the parser waits for byte 0 after reset
        push_text("P6 1 1 9 ", 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(ppmp_pkg::CH_SIX, 1'b0); // past the last pixel: dropped
        push_text("XP", 1'b1);             // bad first byte, then ignored
        push_text("P7", 1'b1);             // bad second byte
        push_text("P3\nx", 1'b1);          // no digits anywhere: empty image
        push_text("P3\t999999#", 1'b1);    // width saturates, rest empty

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            @(negedge i_clk);
            send_idle_pct = idle_tab[ph];
            out_stall_pct = stall_tab[ph];
            stim_count = 0;
            while (stim_count < PHASE_BYTES) gen_file();
            // hold further bytes until every parsed result has come out
            do @(negedge i_clk);
            while (file_bytes.size() != 0 || i_in_valid || parsed_results.size() != 0);
        end

        repeat (20) @(negedge i_clk);
        if (parsed_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", parsed_results.size()));
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
